@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ design/isq_pkg.sv @@
// Shared codes, widths and types for the indexed sequence store.
package isq_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PREPEND    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAKE_LAST  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE_FIRST = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd6;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Per-cycle cell operations
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;  // cell at index loads value
  localparam logic [1:0] OP_OPEN  = 2'd2;  // cells above index shift up, index loads value
  localparam logic [1:0] OP_CLOSE = 2'd3;  // cells from index on take right neighbor

  // Broadcast to every cell in the row
  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ design/indexed_sequence_store.sv @@
// Top level of the indexed sequence store: control, cell row and result register.
//
//  Channel  | Direction | Contents
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | command: cmd, position, item_value
//  m_*      | out       | result: status, result_value, count
//
// One command per cycle while results are taken: every cell decides its next
// content from its own value and its two neighbors, so a result is registered
// and valid in the cycle after the command transfer.
// Reset clears the element count and the result valid; cell contents are
// left as they are. A stalled result holds; a new command is taken in the
// same cycle the pending result is taken.
module indexed_sequence_store import isq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cmd[2:0], position[10:3], item_value[42:11], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], result_value[33:2], count[38:34], zero pad
);

`include "assert_macros.svh"

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                fire;
  logic [CMD_W-1:0]    cmd;
  logic [POS_W-1:0]    position;
  logic [VAL_W-1:0]    item_value;
  cell_cmd_t           cell_cmd;
  logic [IW-1:0]       at;
  logic [IW-1:0]       rd_idx;
  logic                rd_en;
  logic [STATUS_W-1:0] status;
  logic [CW-1:0]       occ;
  logic [CW-1:0]       occ_next;
  logic [VAL_W-1:0]    cell_value [DEPTH];
  logic [VAL_W-1:0]    result_value;
  logic [STATUS_W-1:0] status_q;
  logic [VAL_W-1:0]    result_q;
  logic [COUNT_W-1:0]  count_q;

  // Input unpacking
  assign cmd        = s_tdata[2:0];
  assign position   = s_tdata[10:3];
  assign item_value = s_tdata[42:11];

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  isq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (cmd),
    .position   (position),
    .item_value (item_value),
    .cell_cmd   (cell_cmd),
    .at         (at),
    .rd_idx     (rd_idx),
    .rd_en      (rd_en),
    .status     (status),
    .occ        (occ),
    .occ_next   (occ_next)
  );

  // Row of cells; the ends see the load value and their own content
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_cmd.value;
    end else begin : g_inner_l
      assign left_v = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_inner_r
      assign right_v = cell_value[i+1];
    end
    isq_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .at          (at),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i])
    );
  end

  // Read port: element before the row moves
  assign result_value = rd_en ? cell_value[rd_idx] : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_q <= status;
      result_q <= result_value;
      count_q  <= COUNT_W'(occ_next);
    end
  end

  assign m_tdata = {1'b0, count_q, result_q, status_q};

  // Checks
  `ASSERT_IMPLIES(a_occ_bound, 1'b1, occ <= CW'(DEPTH))
  `ASSERT_NEXT(a_fail_keeps_count, fire && status != ST_OK, $stable(occ))
  `ASSERT_IMPLIES(a_fail_zero_value, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[33:2] == '0)
  `ASSERT_NEXT(a_fire_gives_result, fire, m_tvalid)

endmodule

@@ design/isq_cell.sv @@
// One storage cell of the row: holds one element and trades with its neighbors.
module isq_cell import isq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  cell_cmd_t                  cmd,
  input  logic [$clog2(DEPTH)-1:0]   at,
  input  logic [VAL_W-1:0]           left_value,
  input  logic [VAL_W-1:0]           right_value,
  output logic [VAL_W-1:0]           value
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic             at_me;
  logic             above;
  logic [VAL_W-1:0] value_next;

  assign at_me = (at == MY_IDX);
  assign above = (MY_IDX > at);

  // Select the next content from hold, load, left or right
  always_comb begin
    value_next = value;
    case (cmd.op)
      OP_WRITE: begin
        if (at_me) value_next = cmd.value;
      end
      OP_OPEN: begin
        if (at_me) value_next = cmd.value;
        else if (above) value_next = left_value;
      end
      OP_CLOSE: begin
        if (at_me || above) value_next = right_value;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ design/isq_ctrl.sv @@
// Command decode, range checks and element count for the store.
module isq_ctrl import isq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [CMD_W-1:0]             cmd,
  input  logic [POS_W-1:0]             position,
  input  logic [VAL_W-1:0]             item_value,
  output cell_cmd_t                    cell_cmd,
  output logic [$clog2(DEPTH)-1:0]     at,
  output logic [$clog2(DEPTH)-1:0]     rd_idx,
  output logic                         rd_en,
  output logic [STATUS_W-1:0]          status,
  output logic [$clog2(DEPTH+1)-1:0]   occ,
  output logic [$clog2(DEPTH+1)-1:0]   occ_next
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic          full;
  logic          empty;
  logic          idx_ok;
  logic [1:0]    op;
  logic [IW-1:0] pos_idx;
  logic [IW-1:0] back_idx;
  logic [CW-1:0] occ_inc;
  logic [CW-1:0] occ_dec;

  assign full     = (occ == FULL_CNT);
  assign empty    = (occ == '0);
  assign idx_ok   = (AW'(position) < AW'(occ));
  assign pos_idx  = position[IW-1:0];
  assign back_idx = IW'(occ - 1'b1);
  assign occ_inc  = CW'(occ + 1'b1);
  assign occ_dec  = CW'(occ - 1'b1);

  // Decode one command into a row operation and a result
  always_comb begin
    op       = OP_HOLD;
    at       = '0;
    rd_idx   = '0;
    rd_en    = 1'b0;
    status   = ST_OK;
    occ_next = occ;
    case (cmd)
      CMD_APPEND: begin
        if (full) status = ST_FULL;
        else begin
          op       = OP_WRITE;
          at       = occ[IW-1:0];
          occ_next = occ_inc;
        end
      end
      CMD_PREPEND: begin
        if (full) status = ST_FULL;
        else begin
          op       = OP_OPEN;
          occ_next = occ_inc;
        end
      end
      CMD_TAKE_LAST: begin
        if (empty) status = ST_EMPTY;
        else begin
          rd_en    = 1'b1;
          rd_idx   = back_idx;
          occ_next = occ_dec;
        end
      end
      CMD_TAKE_FIRST: begin
        if (empty) status = ST_EMPTY;
        else begin
          op       = OP_CLOSE;
          rd_en    = 1'b1;
          occ_next = occ_dec;
        end
      end
      CMD_READ: begin
        if (!idx_ok) status = ST_BAD_INDEX;
        else begin
          rd_en  = 1'b1;
          rd_idx = pos_idx;
        end
      end
      CMD_WRITE: begin
        if (!idx_ok) status = ST_BAD_INDEX;
        else begin
          op = OP_WRITE;
          at = pos_idx;
        end
      end
      CMD_INSERT: begin
        if (!idx_ok) status = ST_BAD_INDEX;
        else if (full) status = ST_FULL;
        else begin
          op       = OP_OPEN;
          at       = pos_idx;
          occ_next = occ_inc;
        end
      end
      CMD_ERASE: begin
        if (!idx_ok) status = ST_BAD_INDEX;
        else begin
          op       = OP_CLOSE;
          at       = pos_idx;
          rd_en    = 1'b1;
          rd_idx   = pos_idx;
          occ_next = occ_dec;
        end
      end
      default: status = ST_OK;
    endcase
  end

  // Row only moves on an accepted transfer
  assign cell_cmd.op    = fire ? op : OP_HOLD;
  assign cell_cmd.value = item_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (fire) begin
      occ <= occ_next;
    end
  end

endmodule

@@ bench/sequence_store_checker.sv @@
// Checker for the indexed sequence store: tracks accepted commands, predicts results, compares.
`timescale 1ns / 100ps

module sequence_store_checker import isq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          mismatches,
  output int          pending,
  output int          results_checked,
  output int          hits_ok,
  output int          hits_empty,
  output int          hits_bad_index,
  output int          hits_full
);

  localparam int EXP_SLOTS = 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value;
    logic [COUNT_W-1:0]  count;
  } store_result_t;

  // Shadow copy of the store contents and element count
  logic [VAL_W-1:0] shadow_entries [DEPTH];
  int               shadow_count;

  // Expected results in transfer order, as a small ring buffer
  store_result_t    expected_fifo [EXP_SLOTS];
  int               exp_wr;
  int               exp_rd;
  int               exp_fill;

  // Apply one command to the shadow store and return the result it should give
  function automatic store_result_t predict_store_cmd(input logic [CMD_W-1:0] op,
                                                      input logic [POS_W-1:0] idx,
                                                      input logic [VAL_W-1:0] val);
    store_result_t r;
    logic          is_full;
    logic          idx_ok;
    int            at;
    r        = '0;
    r.status = ST_OK;
    is_full  = (shadow_count >= DEPTH);
    idx_ok   = (int'(idx) < shadow_count);
    at       = int'(idx);
    case (op)
      CMD_APPEND: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
        end
      end
      CMD_PREPEND: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = val;
          shadow_count++;
        end
      end
      CMD_TAKE_LAST: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
          r.value = shadow_entries[shadow_count];
        end
      end
      CMD_TAKE_FIRST: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = shadow_entries[0];
          for (int i = 0; i < shadow_count - 1; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (!idx_ok) r.status = ST_BAD_INDEX;
        else r.value = shadow_entries[at];
      end
      CMD_WRITE: begin
        if (!idx_ok) r.status = ST_BAD_INDEX;
        else shadow_entries[at] = val;
      end
      CMD_INSERT: begin
        // index check wins over the full check
        if (!idx_ok) begin
          r.status = ST_BAD_INDEX;
        end else if (is_full) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[at] = val;
          shadow_count++;
        end
      end
      default: begin  // CMD_ERASE
        if (!idx_ok) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.value = shadow_entries[at];
          for (int i = at; i < shadow_count - 1; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  // Predict on every command transfer, compare on every result transfer
  always @(posedge clk) begin
    store_result_t want;
    store_result_t got;
    int            bad;
    bad = 0;
    if (rst) begin
      shadow_count = 0;
      exp_wr       = 0;
      exp_rd       = 0;
      exp_fill     = 0;
      mismatches      <= 0;
      results_checked <= 0;
      hits_ok         <= 0;
      hits_empty      <= 0;
      hits_bad_index  <= 0;
      hits_full       <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        want = predict_store_cmd(s_tdata[2:0], s_tdata[10:3], s_tdata[42:11]);
        if (exp_fill == EXP_SLOTS) begin
          $error("more than %0d results outstanding", EXP_SLOTS);
          bad++;
        end else begin
          expected_fifo[exp_wr] = want;
          exp_wr = (exp_wr + 1) % EXP_SLOTS;
          exp_fill++;
        end
        case (want.status)
          ST_OK:        hits_ok        <= hits_ok + 1;
          ST_EMPTY:     hits_empty     <= hits_empty + 1;
          ST_BAD_INDEX: hits_bad_index <= hits_bad_index + 1;
          default:      hits_full      <= hits_full + 1;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.value  = m_tdata[33:2];
        got.count  = m_tdata[38:34];
        if (exp_fill == 0) begin
          $error("result transfer with nothing expected: status %0d value %0d count %0d",
                 got.status, $signed(got.value), got.count);
          bad++;
        end else begin
          want = expected_fifo[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_SLOTS;
          exp_fill--;
          results_checked <= results_checked + 1;
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
          end
          if (got.value !== want.value) begin
            $error("result_value: expected %0d, actual %0d",
                   $signed(want.value), $signed(got.value));
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count);
          end
          if (got !== want) bad++;
        end
      end
      mismatches <= mismatches + bad;
    end
    pending <= exp_fill;
  end

endmodule

@@ bench/testbench.sv @@
// Top of the indexed sequence store bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module testbench import isq_pkg::*; ();

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 4;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;  // cmd[2:0], position[10:3], item_value[42:11], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // status[1:0], result_value[33:2], count[38:34], zero pad

  int mismatches, pending, results_checked;
  int hits_ok, hits_empty, hits_bad_index, hits_full;
  int cmds_sent;
  int quiet_cycles;
  int results_taken;

  indexed_sequence_store #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sequence_store_checker #(.DEPTH(DEPTH)) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .hits_ok         (hits_ok),
    .hits_empty      (hits_empty),
    .hits_bad_index  (hits_bad_index),
    .hits_full       (hits_full)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up after a long stretch with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result sink: random stall per result, with stall-free stretches
  initial begin
    int stall;
    results_taken = 0;
    @(posedge clk iff !rst);
    forever begin
      stall = ((results_taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      results_taken++;
    end
  end

  // One command transfer, after a random gap unless in a back-to-back stretch
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] idx,
                          input logic [VAL_W-1:0] val);
    int gap;
    gap = ((cmds_sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {5'b0, val, idx, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    cmds_sent++;
  endtask

  // Command mix leans toward growth or shrinkage so the store swings full and empty
  function automatic logic [CMD_W-1:0] pick_cmd(input logic grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 25) return CMD_APPEND;
      if (r < 50) return CMD_PREPEND;
      if (r < 62) return CMD_INSERT;
      if (r < 70) return CMD_TAKE_LAST;
      if (r < 76) return CMD_TAKE_FIRST;
      if (r < 84) return CMD_READ;
      if (r < 92) return CMD_WRITE;
      return CMD_ERASE;
    end
    if (r < 5)  return CMD_APPEND;
    if (r < 10) return CMD_PREPEND;
    if (r < 15) return CMD_INSERT;
    if (r < 40) return CMD_TAKE_LAST;
    if (r < 60) return CMD_TAKE_FIRST;
    if (r < 70) return CMD_READ;
    if (r < 80) return CMD_WRITE;
    return CMD_ERASE;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Reset, directed commands, random commands, drain, verdict
  initial begin
    int directed_items;
    logic grow;
    logic [POS_W-1:0] idx;
    cmds_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store: pops flag empty, insert cannot add the first element
    send_cmd(CMD_TAKE_LAST,  8'd0,   32'h1234_5678);
    send_cmd(CMD_TAKE_FIRST, 8'd0,   32'h0);
    send_cmd(CMD_INSERT,     8'd0,   32'h5555_AAAA);
    send_cmd(CMD_APPEND,     8'd0,   32'h7FFF_FFFF);
    send_cmd(CMD_PREPEND,    8'd255, 32'h8000_0000);
    // insert at the head only prepends
    send_cmd(CMD_INSERT,     8'd0,   32'h0000_0001);
    send_cmd(CMD_WRITE,      8'd2,   32'hFFFF_FFFF);
    send_cmd(CMD_READ,       8'd255, 32'h0);
    // fill to the top
    for (int i = 0; i < DEPTH - 3; i++) begin
      send_cmd((i % 2) ? CMD_PREPEND : CMD_APPEND, 8'(i), pick_value());
    end
    send_cmd(CMD_APPEND,     8'd0,   32'hDEAD_0001);
    // bad index is reported before full
    send_cmd(CMD_INSERT,     8'd16,  32'hDEAD_0002);
    send_cmd(CMD_INSERT,     8'd3,   32'hDEAD_0003);
    send_cmd(CMD_READ,       8'd15,  32'h0);
    send_cmd(CMD_ERASE,      8'd0,   32'h0);
    send_cmd(CMD_TAKE_FIRST, 8'd0,   32'h0);
    send_cmd(CMD_TAKE_LAST,  8'd0,   32'h0);
    directed_items = cmds_sent;

    // random phases alternating between growth and shrinkage
    grow = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) grow = (n / 60) % 2 == 0;
      idx = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, DEPTH))
                                         : 8'($urandom_range(0, 255));
      send_cmd(pick_cmd(grow), idx, pick_value());
    end
    s_tvalid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d commands (%0d directed, %0d random), %0d results checked",
             cmds_sent, directed_items, cmds_sent - directed_items, results_checked);
    $display("Status seen: ok %0d, empty %0d, bad index %0d, full %0d",
             hits_ok, hits_empty, hits_bad_index, hits_full);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/isq_pkg.sv
design/isq_cell.sv
design/isq_ctrl.sv
design/indexed_sequence_store.sv
bench/sequence_store_checker.sv
bench/testbench.sv
